@@ design/ntwa_pkg.sv @@
// Shared types and codes for the neighbor table with aging.
package ntwa_pkg;

	// Item kinds.
	localparam logic [2:0] KIND_REGISTER = 3'd0;
	localparam logic [2:0] KIND_SWEEP    = 3'd1;
	localparam logic [2:0] KIND_FIND     = 3'd2;
	localparam logic [2:0] KIND_READ     = 3'd3;
	localparam logic [2:0] KIND_MARK     = 3'd4;
	localparam logic [2:0] KIND_CLEAR    = 3'd5;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NEW      = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// Timeout register value after reset, in milliseconds.
	localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

	// One table entry as it sits in the entry memory.
	typedef struct packed {
		logic [7:0]  id;
		logic [47:0] mac;
		logic        relay;
		logic [7:0]  rssi;
		logic [31:0] last_seen;
		logic        auth;
	} entry_t;

	// Flags from the shared compare unit.
	typedef struct packed {
		logic id_hit;
		logic expired;
	} match_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_FINISH
	} state_t;

endpackage

@@ design/ntwa_match_unit.sv @@
// Shared compare unit: id match and 32-bit wrapping age against the timeout.
module ntwa_match_unit (
	input  ntwa_pkg::entry_t ent,
	input  logic [7:0]       id,
	input  logic [31:0]      now_ms,
	input  logic [31:0]      timeout_ms,
	output ntwa_pkg::match_t match
);

	logic [31:0] age;

	// Age wraps modulo 2^32; an entry expires when its age is strictly above the timeout.
	always_comb begin
		age           = now_ms - ent.last_seen;
		match.expired = (age > timeout_ms);
		match.id_hit  = (ent.id == id);
	end

endmodule

@@ design/neighbor_table_with_aging_unit.sv @@
// Neighbor table with timeout aging: sequencer, entry memory and result register.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-------------------------------
//  input   | kind now_ms node_id node_mac ...      | in_valid / in_ready
//  result  | status entry_count found_* removed_*  | out_valid / out_ready
//  config  | cfg_wr_data (timeout_ms)              | cfg_wr_en, written at once
//
// Each entry visited takes a memory read state and a compare state, through the single
// read port of the entry memory. Register, find and mark visit entries up to the first id
// hit, a sweep visits every entry, read by index visits one entry (none on a miss), and
// clear and the unused kinds visit none.
// Reset clears the entry count and the sequencer; the entry memory is not cleared.
// The result is held in an output register; a stalled result holds the sequencer in its
// last state, while a new item is taken as soon as the previous result is registered.
module neighbor_table_with_aging_unit #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_wr_en,
	input  logic [31:0]       cfg_wr_data,
	// input item
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [31:0]       now_ms,
	input  logic [7:0]        node_id,
	input  logic [47:0]       node_mac,
	input  logic              relay_on,
	input  logic signed [7:0] signal_rssi,
	input  logic [3:0]        entry_index,
	// result item
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [4:0]        entry_count,
	output logic [7:0]        found_id,
	output logic [47:0]       found_mac,
	output logic              found_relay,
	output logic signed [7:0] found_rssi,
	output logic [31:0]       found_last_seen,
	output logic              found_authenticated,
	output logic [4:0]        removed_count
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int XW = (CW > 4) ? CW : 4;

	ntwa_pkg::state_t state_q, state_d;

	logic [31:0]       timeout_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     wr_ptr_q;
	logic [CW-1:0]     removed_q;
	logic              hit_q;
	logic [2:0]        kind_q;
	logic [31:0]       now_q;
	logic [7:0]        id_q;
	logic [47:0]       mac_q;
	logic              relay_q;
	logic [7:0]        rssi_q;

	ntwa_pkg::entry_t  mem [MAX_ENTRIES];
	ntwa_pkg::entry_t  rd_data_q;
	ntwa_pkg::entry_t  mem_wdata;
	logic [AW-1:0]     mem_waddr;
	logic              mem_we;
	logic              rd_en;
	ntwa_pkg::match_t  match;

	logic              accept;
	logic              check_phase;
	logic              fin_phase;
	logic              fin_go;
	logic              is_full;
	logic              is_last;
	logic [CW-1:0]     scan_nx;
	logic [XW-1:0]     idx_x;
	logic              idx_in_range;
	logic              start_scan;

	logic [1:0]        res_status;
	logic [CW-1:0]     res_count;
	logic              res_show;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [4:0]        entry_count_q;
	ntwa_pkg::entry_t  found_q;
	logic [4:0]        removed_count_q;

	// Shared compare unit on the entry just read.
	ntwa_match_unit u_match (
		.ent        (rd_data_q),
		.id         (id_q),
		.now_ms     (now_q),
		.timeout_ms (timeout_q),
		.match      (match)
	);

	// Helper terms for the sequencer.
	always_comb begin
		idx_x        = XW'(entry_index);
		idx_in_range = (idx_x < XW'(count_q));
		scan_nx      = scan_q + 1'b1;
		is_last      = (scan_nx == count_q);
		is_full      = (count_q == CW'(MAX_ENTRIES));
		accept       = in_valid && in_ready;
		fin_go       = fin_phase && (!out_valid_q || out_ready);
		case (kind)
			ntwa_pkg::KIND_REGISTER,
			ntwa_pkg::KIND_SWEEP,
			ntwa_pkg::KIND_FIND,
			ntwa_pkg::KIND_MARK: start_scan = (count_q != '0);
			ntwa_pkg::KIND_READ: start_scan = idx_in_range;
			default:             start_scan = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ntwa_pkg::S_IDLE: begin
				if (accept) begin
					state_d = start_scan ? ntwa_pkg::S_READ : ntwa_pkg::S_FINISH;
				end
			end
			ntwa_pkg::S_READ: begin
				state_d = ntwa_pkg::S_CHECK;
			end
			ntwa_pkg::S_CHECK: begin
				case (kind_q)
					ntwa_pkg::KIND_SWEEP: begin
						state_d = is_last ? ntwa_pkg::S_FINISH : ntwa_pkg::S_READ;
					end
					ntwa_pkg::KIND_READ: begin
						state_d = ntwa_pkg::S_FINISH;
					end
					default: begin
						state_d = (match.id_hit || is_last) ? ntwa_pkg::S_FINISH
						                                    : ntwa_pkg::S_READ;
					end
				endcase
			end
			ntwa_pkg::S_FINISH: begin
				if (fin_go) begin
					state_d = ntwa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ntwa_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready    = 1'b0;
		rd_en       = 1'b0;
		check_phase = 1'b0;
		fin_phase   = 1'b0;
		case (state_q)
			ntwa_pkg::S_IDLE:   in_ready    = 1'b1;
			ntwa_pkg::S_READ:   rd_en       = 1'b1;
			ntwa_pkg::S_CHECK:  check_phase = 1'b1;
			ntwa_pkg::S_FINISH: fin_phase   = 1'b1;
			default:            in_ready    = 1'b0;
		endcase
	end

	// State and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ntwa_pkg::S_IDLE;
			timeout_q <= ntwa_pkg::TIMEOUT_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
		end
	end

	// Item fields and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			wr_ptr_q  <= '0;
			removed_q <= '0;
			hit_q     <= 1'b0;
			kind_q    <= ntwa_pkg::KIND_CLEAR;
		end else if (accept) begin
			scan_q    <= (kind == ntwa_pkg::KIND_READ && idx_in_range) ? CW'(idx_x) : '0;
			wr_ptr_q  <= '0;
			removed_q <= '0;
			hit_q     <= 1'b0;
			kind_q    <= kind;
		end else if (check_phase) begin
			case (kind_q)
				ntwa_pkg::KIND_SWEEP: begin
					if (match.expired) begin
						removed_q <= removed_q + 1'b1;
					end else begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
					scan_q <= scan_nx;
				end
				ntwa_pkg::KIND_READ: begin
					hit_q <= 1'b1;
				end
				default: begin
					if (match.id_hit) begin
						hit_q <= 1'b1;
					end else begin
						scan_q <= scan_nx;
					end
				end
			endcase
		end
	end

	// Payload of the accepted item.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= now_ms;
			id_q    <= node_id;
			mac_q   <= node_mac;
			relay_q <= relay_on;
			rssi_q  <= signal_rssi;
		end
	end

	// Memory write port: compaction during a sweep, new entry or update on register, or mark at the end.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_q[AW-1:0];
		mem_wdata = rd_data_q;
		if (check_phase && kind_q == ntwa_pkg::KIND_SWEEP && !match.expired) begin
			mem_we    = 1'b1;
			mem_waddr = wr_ptr_q[AW-1:0];
		end else if (fin_go && kind_q == ntwa_pkg::KIND_REGISTER) begin
			mem_wdata.mac       = mac_q;
			mem_wdata.relay     = relay_q;
			mem_wdata.rssi      = rssi_q;
			mem_wdata.last_seen = now_q;
			if (hit_q) begin
				mem_we = 1'b1;
			end else if (!is_full) begin
				mem_we         = 1'b1;
				mem_waddr      = count_q[AW-1:0];
				mem_wdata.id   = id_q;
				mem_wdata.auth = 1'b0;
			end
		end else if (fin_go && kind_q == ntwa_pkg::KIND_MARK && hit_q) begin
			mem_we         = 1'b1;
			mem_wdata.auth = 1'b1;
		end
	end

	// Entry memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_q <= mem[scan_q[AW-1:0]];
		end
	end

	// Result of the finished item.
	always_comb begin
		res_status = ntwa_pkg::STAT_OK;
		res_count  = count_q;
		res_show   = 1'b0;
		case (kind_q)
			ntwa_pkg::KIND_REGISTER: begin
				if (hit_q) begin
					res_status = ntwa_pkg::STAT_OK;
				end else if (is_full) begin
					res_status = ntwa_pkg::STAT_FULL;
				end else begin
					res_status = ntwa_pkg::STAT_NEW;
					res_count  = count_q + 1'b1;
				end
			end
			ntwa_pkg::KIND_SWEEP: begin
				res_count = wr_ptr_q;
			end
			ntwa_pkg::KIND_FIND,
			ntwa_pkg::KIND_READ: begin
				res_status = hit_q ? ntwa_pkg::STAT_OK : ntwa_pkg::STAT_NOTFOUND;
				res_show   = hit_q;
			end
			ntwa_pkg::KIND_MARK: begin
				res_status = hit_q ? ntwa_pkg::STAT_OK : ntwa_pkg::STAT_NOTFOUND;
			end
			ntwa_pkg::KIND_CLEAR: begin
				res_count = '0;
			end
			default: begin
				res_status = ntwa_pkg::STAT_OK;
			end
		endcase
	end

	// Entry count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			count_q     <= res_count;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (fin_go) begin
			status_q        <= res_status;
			entry_count_q   <= 5'(res_count);
			found_q         <= res_show ? rd_data_q : '0;
			removed_count_q <= 5'(removed_q);
		end
	end

	assign out_valid           = out_valid_q;
	assign status              = status_q;
	assign entry_count         = entry_count_q;
	assign found_id            = found_q.id;
	assign found_mac           = found_q.mac;
	assign found_relay         = found_q.relay;
	assign found_rssi          = $signed(found_q.rssi);
	assign found_last_seen     = found_q.last_seen;
	assign found_authenticated = found_q.auth;
	assign removed_count       = removed_count_q;

endmodule

@@ design/ntwa_checker.sv @@
// Port-level assertions for the neighbor table, bound to the top level.
module ntwa_checker #(
	parameter int MAX_ENTRIES = 16
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [4:0] entry_count,
	input logic [4:0] removed_count
);

	// An accepted item keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input accepted on two consecutive cycles");

	// A stalled result stays valid and holds its status and entry count.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
	else $error("stalled result changed");

	// A full report comes only with a full table.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ntwa_pkg::STAT_FULL |-> entry_count == 5'(MAX_ENTRIES))
	else $error("table full reported below capacity");

	// A new entry leaves at least one entry in the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ntwa_pkg::STAT_NEW |-> entry_count != 5'd0)
	else $error("new entry reported with an empty table");

	// A nonzero removed count, which only a sweep reports, always comes with an ok status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && removed_count != 5'd0 |-> status == ntwa_pkg::STAT_OK)
	else $error("removed entries with a non-ok status");

endmodule

bind neighbor_table_with_aging_unit ntwa_checker #(
	.MAX_ENTRIES (MAX_ENTRIES)
) u_ntwa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.entry_count   (entry_count),
	.removed_count (removed_count)
);

@@ tb/sv/ntwa_tb_pkg.sv @@
`timescale 1ns / 1ps
// Request and reply types, plus the scoreboard that predicts and checks neighbor table replies.
package ntwa_tb_pkg;

	localparam int TABLE_DEPTH = 16;

	// One input item as the testbench drives it.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] now;
		logic [7:0]  id;
		logic [47:0] mac;
		logic        relay;
		logic [7:0]  rssi;
		logic [3:0]  idx;
	} request_t;

	// One result item as the block returns it.
	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  count;
		logic [7:0]  id;
		logic [47:0] mac;
		logic        relay;
		logic [7:0]  rssi;
		logic [31:0] last_seen;
		logic        auth;
		logic [4:0]  removed;
	} reply_t;

	class neighbor_table_scoreboard;
		logic [31:0]      timeout_ms;
		int unsigned      live_count;
		ntwa_pkg::entry_t slots [TABLE_DEPTH];
		reply_t           replies_due [$];
		int unsigned      mismatches;

		function new();
			timeout_ms = ntwa_pkg::TIMEOUT_RESET;
			live_count = 0;
			mismatches = 0;
		endfunction

		// First live slot holding this id, or live_count on a miss.
		function int unsigned position_of(logic [7:0] id);
			int unsigned i;
			for (i = 0; i < live_count; i++) begin
				if (slots[i].id == id)
					return i;
			end
			return live_count;
		endfunction

		// Copy a stored entry into the returned fields of a reply.
		function reply_t with_entry(reply_t rp, ntwa_pkg::entry_t e);
			rp.id        = e.id;
			rp.mac       = e.mac;
			rp.relay     = e.relay;
			rp.rssi      = e.rssi;
			rp.last_seen = e.last_seen;
			rp.auth      = e.auth;
			return rp;
		endfunction

		// Apply one request to the table copy and work out the reply it causes.
		function reply_t apply_request(request_t rq);
			reply_t      rp;
			int unsigned p;
			int unsigned i;
			int unsigned kept;
			logic [31:0] age;
			rp = '0;
			case (rq.kind)
				ntwa_pkg::KIND_REGISTER: begin
					p = position_of(rq.id);
					if (p < live_count) begin
						rp.status = ntwa_pkg::STAT_OK;
					end else if (live_count >= TABLE_DEPTH) begin
						rp.status = ntwa_pkg::STAT_FULL;
					end else begin
						p = live_count;
						slots[p].id = rq.id;
						slots[p].auth = 1'b0;
						live_count++;
						rp.status = ntwa_pkg::STAT_NEW;
					end
					if (rp.status != ntwa_pkg::STAT_FULL) begin
						slots[p].relay     = rq.relay;
						slots[p].rssi      = rq.rssi;
						slots[p].last_seen = rq.now;
						slots[p].mac       = rq.mac;
					end
				end
				ntwa_pkg::KIND_SWEEP: begin
					// Drop stale entries and close the gaps, keeping the order.
					kept = 0;
					for (i = 0; i < live_count; i++) begin
						age = rq.now - slots[i].last_seen;
						if (age > timeout_ms) begin
							rp.removed = rp.removed + 5'd1;
						end else begin
							slots[kept] = slots[i];
							kept++;
						end
					end
					live_count = kept;
				end
				ntwa_pkg::KIND_FIND: begin
					p = position_of(rq.id);
					if (p < live_count)
						rp = with_entry(rp, slots[p]);
					else
						rp.status = ntwa_pkg::STAT_NOTFOUND;
				end
				ntwa_pkg::KIND_READ: begin
					if (rq.idx < live_count)
						rp = with_entry(rp, slots[rq.idx]);
					else
						rp.status = ntwa_pkg::STAT_NOTFOUND;
				end
				ntwa_pkg::KIND_MARK: begin
					p = position_of(rq.id);
					if (p < live_count)
						slots[p].auth = 1'b1;
					else
						rp.status = ntwa_pkg::STAT_NOTFOUND;
				end
				ntwa_pkg::KIND_CLEAR: begin
					live_count = 0;
				end
				default: begin
				end
			endcase
			rp.count = 5'(live_count);
			return rp;
		endfunction

		function void log_request(request_t rq);
			replies_due.push_back(apply_request(rq));
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Check an accepted reply against the oldest prediction.
		function void check_reply(reply_t got);
			reply_t want;
			if (replies_due.size() == 0) begin
				$error("reply with no request waiting, status %0d", got.status);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("entry_count", want.count, got.count);
			compare_field("found_id", want.id, got.id);
			compare_field("found_mac", want.mac, got.mac);
			compare_field("found_relay", want.relay, got.relay);
			compare_field("found_rssi", $signed(want.rssi), $signed(got.rssi));
			compare_field("found_last_seen", want.last_seen, got.last_seen);
			compare_field("found_authenticated", want.auth, got.auth);
			compare_field("removed_count", want.removed, got.removed);
		endfunction
	endclass

endpackage

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Top-level testbench for the neighbor table with aging: stimulus, handshakes and watchdog.
module testbench;

	localparam int STALL_LIMIT     = 5000;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int SETTLE_CYCLES   = 40;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [31:0]       cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [2:0]        kind        = '0;
	logic [31:0]       now_ms      = '0;
	logic [7:0]        node_id     = '0;
	logic [47:0]       node_mac    = '0;
	logic              relay_on    = 1'b0;
	logic signed [7:0] signal_rssi = '0;
	logic [3:0]        entry_index = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [1:0]        status;
	logic [4:0]        entry_count;
	logic [7:0]        found_id;
	logic [47:0]       found_mac;
	logic              found_relay;
	logic signed [7:0] found_rssi;
	logic [31:0]       found_last_seen;
	logic              found_authenticated;
	logic [4:0]        removed_count;

	ntwa_tb_pkg::neighbor_table_scoreboard board = new();

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          quiet         = 1'b0;
	int          stall_cycles  = 0;
	logic [31:0] clock_ms      = '0;
	logic [31:0] step_ms       = 32'd1000;
	logic [7:0]  id_base       = '0;

	neighbor_table_with_aging_unit dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wr_en           (cfg_wr_en),
		.cfg_wr_data         (cfg_wr_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.kind                (kind),
		.now_ms              (now_ms),
		.node_id             (node_id),
		.node_mac            (node_mac),
		.relay_on            (relay_on),
		.signal_rssi         (signal_rssi),
		.entry_index         (entry_index),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.status              (status),
		.entry_count         (entry_count),
		.found_id            (found_id),
		.found_mac           (found_mac),
		.found_relay         (found_relay),
		.found_rssi          (found_rssi),
		.found_last_seen     (found_last_seen),
		.found_authenticated (found_authenticated),
		.removed_count       (removed_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Take results and stall the result channel at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_reply(ntwa_tb_pkg::reply_t'{status, entry_count, found_id, found_mac,
				found_relay, found_rssi, found_last_seen, found_authenticated,
				removed_count});
		out_ready <= quiet || ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// End the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic ntwa_tb_pkg::request_t make_request(logic [2:0] k, logic [31:0] t,
		logic [7:0] id, logic [47:0] mac, logic relay, logic [7:0] rssi, logic [3:0] idx);
		ntwa_tb_pkg::request_t rq;
		rq = '{k, t, id, mac, relay, rssi, idx};
		return rq;
	endfunction

	// Mostly well-formed traffic around a running clock, with some noise mixed in.
	function automatic ntwa_tb_pkg::request_t random_request();
		ntwa_tb_pkg::request_t rq;
		int unsigned           pick;
		clock_ms = clock_ms + $urandom_range(0, step_ms);
		rq.now   = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
		rq.id    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : id_base ^ 8'($urandom_range(0, 19));
		rq.mac   = 48'({$urandom, $urandom});
		rq.relay = 1'($urandom_range(0, 1));
		rq.rssi  = 8'($urandom);
		rq.idx   = 4'($urandom);
		pick     = $urandom_range(0, 99);
		if (pick < 40)
			rq.kind = ntwa_pkg::KIND_REGISTER;
		else if (pick < 50)
			rq.kind = ntwa_pkg::KIND_SWEEP;
		else if (pick < 65)
			rq.kind = ntwa_pkg::KIND_FIND;
		else if (pick < 80)
			rq.kind = ntwa_pkg::KIND_READ;
		else if (pick < 96)
			rq.kind = ntwa_pkg::KIND_MARK;
		else if (pick < 98)
			rq.kind = ntwa_pkg::KIND_CLEAR;
		else
			rq.kind = 3'($urandom_range(6, 7));
		return rq;
	endfunction

	// Present one item, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_request(ntwa_tb_pkg::request_t rq);
		while (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= rq.kind;
		now_ms      <= rq.now;
		node_id     <= rq.id;
		node_mac    <= rq.mac;
		relay_on    <= rq.relay;
		signal_rssi <= rq.rssi;
		entry_index <= rq.idx;
		do @(posedge clk); while (!in_ready);
		board.log_request(rq);
	endtask

	task automatic wait_for_replies();
		in_valid <= 1'b0;
		while (board.replies_due.size() != 0)
			@(posedge clk);
	endtask

	// The timeout register is only written with the block idle.
	task automatic set_timeout(logic [31:0] value);
		wait_for_replies();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		board.timeout_ms = value;
	endtask

	initial begin
		int          i;
		int          phase;
		int          n;
		logic [31:0] limit;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, field extremes, update, mark, misses, full table, sweep.
		send_request(make_request(ntwa_pkg::KIND_SWEEP, 32'd0, 8'h00, 48'h0, 1'b0, 8'h00,
			4'd0));
		send_request(make_request(ntwa_pkg::KIND_READ, 32'd0, 8'h00, 48'h0, 1'b0, 8'h00,
			4'hF));
		send_request(make_request(ntwa_pkg::KIND_REGISTER, 32'hFFFF_FFF0, 8'h00, 48'h0, 1'b0,
			8'h80, 4'd0));
		send_request(make_request(ntwa_pkg::KIND_REGISTER, 32'h0000_0010, 8'hFF,
			48'hFFFF_FFFF_FFFF, 1'b1, 8'h7F, 4'd0));
		send_request(make_request(ntwa_pkg::KIND_REGISTER, 32'd9000, 8'h00, 48'h0123_4567_89AB,
			1'b1, 8'hC4, 4'd0));
		send_request(make_request(ntwa_pkg::KIND_MARK, 32'd0, 8'hFF, 48'h0, 1'b0, 8'h00,
			4'd0));
		send_request(make_request(ntwa_pkg::KIND_FIND, 32'd0, 8'hFF, 48'h0, 1'b0, 8'h00,
			4'd0));
		send_request(make_request(ntwa_pkg::KIND_FIND, 32'd0, 8'h4D, 48'h0, 1'b0, 8'h00,
			4'd0));
		for (i = 1; i <= 14; i++)
			send_request(make_request(ntwa_pkg::KIND_REGISTER, 32'd2000 + 32'(100 * (i - 1)),
				8'(i), 48'({$urandom, $urandom}), 1'(i), 8'($urandom), 4'd0));
		send_request(make_request(ntwa_pkg::KIND_REGISTER, 32'd3000, 8'hA5, 48'h0, 1'b0, 8'h00,
			4'd0));
		send_request(make_request(ntwa_pkg::KIND_READ, 32'd0, 8'h00, 48'h0, 1'b0, 8'h00,
			4'hF));
		// Only the entry seen at 0x10 is stale; one entry is exactly at the timeout.
		send_request(make_request(ntwa_pkg::KIND_SWEEP, 32'd12000, 8'h00, 48'h0, 1'b0, 8'h00,
			4'd0));
		send_request(make_request(ntwa_pkg::KIND_READ, 32'd0, 8'h00, 48'h0, 1'b0, 8'h00,
			4'd1));
		send_request(make_request(3'd6, 32'd0, 8'h00, 48'h0, 1'b0, 8'h00, 4'd0));
		send_request(make_request(ntwa_pkg::KIND_CLEAR, 32'd0, 8'h00, 48'h0, 1'b0, 8'h00,
			4'd0));

		// Random phases, each with its own timeout; each pair of phases shares an idling pattern.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				1: limit = 32'd0;
				2: limit = 32'hFFFF_FFFF;
				3: limit = 32'd1;
				5: limit = ntwa_pkg::TIMEOUT_RESET;
				default: limit = $urandom_range(200, 50000);
			endcase
			set_timeout(limit);
			if (limit <= 32'd4)
				step_ms = 32'd2;
			else if (limit == 32'hFFFF_FFFF)
				step_ms = 32'd3000;
			else
				step_ms = limit / 4;
			clock_ms = $urandom;
			id_base  = 8'($urandom);
			case (phase / 2)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == ITEMS_PER_PHASE / 2)
					wait_for_replies();
				if ($urandom_range(0, 19) == 0)
					quiet = !quiet;
				send_request(random_request());
			end
			quiet = 1'b0;
		end

		wait_for_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
